// ----- rtl/rwu_pkg.sv -----
`default_nettype none

package rwu_pkg;

   // field widths
   localparam int unsigned IDX_W      = 12;
   localparam int unsigned WEIGHT_W   = 32;
   localparam int unsigned STEP_W     = 24;
   localparam int unsigned CASE_W     = 2;
   localparam int unsigned SIGN_W     = 2;
   localparam int unsigned CFG_W      = 24;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned PROD_W     = 2 * STEP_W;
   localparam int unsigned REQ_W      = 80;
   localparam int unsigned RSP_W      = 64;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_LEARN_RATE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_MIN   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_MAX   = 2'd2;

   // register reset values
   localparam logic [CFG_W-1:0] LEARN_RATE_RST = 24'd6554;
   localparam logic [CFG_W-1:0] STEP_MIN_RST   = 24'd6554;
   localparam logic [CFG_W-1:0] STEP_MAX_RST   = 24'd3276800;

   // initial step of every entry
   localparam logic [STEP_W-1:0] STEP_RST = 24'd6554;

   // stored sign codes
   localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'd0;
   localparam logic [SIGN_W-1:0] SIGN_POS  = 2'd1;
   localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'd2;

   // update case codes
   localparam logic [CASE_W-1:0] UCASE_GROW   = 2'd0;
   localparam logic [CASE_W-1:0] UCASE_SHRINK = 2'd1;
   localparam logic [CASE_W-1:0] UCASE_KEEP   = 2'd2;

   // floor(s / 5) = (s * DIV5_MUL) >> DIV5_SHIFT, exact for s below 2^26
   localparam logic [STEP_W-1:0] DIV5_MUL   = 24'd13421773;
   localparam int unsigned       DIV5_SHIFT = 26;

   // round half up before dropping 16 fraction bits
   localparam logic [PROD_W-1:0] ROUND_HALF = 48'h00_0000_8000;

   typedef struct packed {
      logic [CFG_W-1:0] learn_rate;
      logic [CFG_W-1:0] step_min;
      logic [CFG_W-1:0] step_max;
   } cfg_type;

   // outcome of the per-entry step rule
   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic [SIGN_W-1:0] sign;
      logic [CASE_W-1:0] ucase;
      logic              move;
   } upd_type;

   // what the weight datapath needs for one word
   typedef struct packed {
      logic signed [WEIGHT_W-1:0] weight;
      logic [STEP_W-1:0]          step;
      logic [CASE_W-1:0]          ucase;
      logic                       move;
      logic                       grad_neg;
   } mv_type;

endpackage

`default_nettype wire

// ----- rtl/rprop_weight_update_unit.sv -----
// pipeline: a word passes stage 1 (memory read), stage 2, stage 3 and the output register
// throughput: one word per cycle unless the output stalls or a clear pass runs; the step/sign
//   memory is read at accept and written back from stage 1; the last write bypasses the next read
// reset: registers return to their reset values and a clear pass then writes every
//   entry to the initial step and zero sign, with req_tready low until the pass ends
`default_nettype none

module rprop_weight_update_unit #(
   parameter int unsigned ENTRIES = 4096
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration
   input  wire logic                              csr_we,
   input  wire logic [rwu_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [rwu_pkg::CFG_W-1:0]         csr_wdata,
   // input words
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [rwu_pkg::REQ_W-1:0]         req_tdata,  // entry_index, weight_in, gradient
   // result words
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [rwu_pkg::RSP_W-1:0]              rsp_tdata   // weight_out, step_out, update_case
);

   localparam int unsigned ADDR_W = $clog2(ENTRIES);
   localparam int unsigned DATA_W = rwu_pkg::SIGN_W + rwu_pkg::STEP_W;
   localparam int unsigned IDX_W  = rwu_pkg::IDX_W;

   rwu_pkg::cfg_type                       cfg_ff;
   logic [IDX_W-1:0]                       req_index;
   logic signed [rwu_pkg::WEIGHT_W-1:0]    req_weight;
   logic signed [rwu_pkg::WEIGHT_W-1:0]    req_grad;
   logic [rwu_pkg::SIGN_W-1:0]             req_gsign;
   logic [ADDR_W-1:0]                      idx;
   logic                                   clr_busy;
   logic                                   adv;
   logic                                   accept;
   logic [DATA_W-1:0]                      rd_data;
   logic                                   s1_valid_ff;
   logic [ADDR_W-1:0]                      s1_idx_ff;
   logic signed [rwu_pkg::WEIGHT_W-1:0]    s1_weight_ff;
   logic [rwu_pkg::SIGN_W-1:0]             s1_gsign_ff;
   logic                                   lw_valid_ff;
   logic [ADDR_W-1:0]                      lw_addr_ff;
   logic [DATA_W-1:0]                      lw_data_ff;
   logic [DATA_W-1:0]                      entry_old;
   rwu_pkg::upd_type                       upd;
   logic                                   wr_en;
   logic [DATA_W-1:0]                      wr_data;
   rwu_pkg::mv_type                        mv;
   logic signed [rwu_pkg::WEIGHT_W-1:0]    weight_out;
   logic [rwu_pkg::STEP_W-1:0]             step_out;
   logic [rwu_pkg::CASE_W-1:0]             update_case;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.learn_rate <= rwu_pkg::LEARN_RATE_RST;
         cfg_ff.step_min   <= rwu_pkg::STEP_MIN_RST;
         cfg_ff.step_max   <= rwu_pkg::STEP_MAX_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            rwu_pkg::CSR_LEARN_RATE: cfg_ff.learn_rate <= csr_wdata;
            rwu_pkg::CSR_STEP_MIN:   cfg_ff.step_min   <= csr_wdata;
            rwu_pkg::CSR_STEP_MAX:   cfg_ff.step_max   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // unpack the input word
   assign req_index  = req_tdata[IDX_W-1:0];
   assign req_weight = req_tdata[IDX_W +: rwu_pkg::WEIGHT_W];
   assign req_grad   = req_tdata[IDX_W+rwu_pkg::WEIGHT_W +: rwu_pkg::WEIGHT_W];
   assign req_gsign  = (req_grad == '0) ? rwu_pkg::SIGN_ZERO :
                       (req_grad[rwu_pkg::WEIGHT_W-1] ? rwu_pkg::SIGN_NEG : rwu_pkg::SIGN_POS);

   // fold the entry index into the store
   generate
      if (ENTRIES >= (1 << IDX_W)) begin : g_idx_wide
         assign idx = ADDR_W'(req_index);
      end else if ((ENTRIES & (ENTRIES - 1)) == 0) begin : g_idx_mask
         assign idx = req_index[ADDR_W-1:0];
      end else begin : g_idx_mod
         logic [IDX_W-1:0] rem;
         always_comb begin
            rem = req_index;
            for (int k = IDX_W - ADDR_W; k >= 0; k--) begin
               if (rem >= (IDX_W'(ENTRIES) << k)) begin
                  rem = rem - (IDX_W'(ENTRIES) << k);
               end
            end
         end
         assign idx = rem[ADDR_W-1:0];
      end
   endgenerate

   // whole pipeline moves when the output register can take a word
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv && !clr_busy;
   assign accept     = req_tvalid && req_tready;

   rwu_state_ram #(
      .ENTRIES (ENTRIES)
   ) u_ram (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (idx),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (s1_idx_ff),
      .wr_data  (wr_data),
      .clr_busy (clr_busy)
   );

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff    <= idx;
         s1_weight_ff <= req_weight;
         s1_gsign_ff  <= req_gsign;
      end
   end

   // bypass the write that lands with the read
   assign entry_old = (lw_valid_ff && (lw_addr_ff == s1_idx_ff)) ? lw_data_ff : rd_data;

   rwu_step_calc u_calc (
      .step_old  (entry_old[rwu_pkg::STEP_W-1:0]),
      .sign_old  (entry_old[DATA_W-1:rwu_pkg::STEP_W]),
      .grad_sign (s1_gsign_ff),
      .cfg       (cfg_ff),
      .upd       (upd)
   );

   // write back the new entry
   assign wr_en   = s1_valid_ff && adv;
   assign wr_data = {upd.sign, upd.step};

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_valid_ff <= 1'b0;
      end else if (wr_en) begin
         lw_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lw_addr_ff <= s1_idx_ff;
         lw_data_ff <= wr_data;
      end
   end

   // hand over to the weight datapath
   assign mv.weight   = s1_weight_ff;
   assign mv.step     = upd.step;
   assign mv.ucase    = upd.ucase;
   assign mv.move     = upd.move;
   assign mv.grad_neg = (s1_gsign_ff == rwu_pkg::SIGN_NEG);

   rwu_weight_move u_move (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (s1_valid_ff),
      .mv          (mv),
      .learn_rate  (cfg_ff.learn_rate),
      .out_valid   (rsp_tvalid),
      .weight_out  (weight_out),
      .step_out    (step_out),
      .update_case (update_case)
   );

   // pack the result word
   assign rsp_tdata = {
      (rwu_pkg::RSP_W - rwu_pkg::WEIGHT_W - rwu_pkg::STEP_W - rwu_pkg::CASE_W)'(0),
      update_case, step_out, weight_out
   };

endmodule

`default_nettype wire

// ----- rtl/rwu_state_ram.sv -----
`default_nettype none

module rwu_state_ram #(
   parameter int unsigned ENTRIES = 4096
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      rd_en,
   input  wire logic [$clog2(ENTRIES)-1:0] rd_addr,
   output logic [rwu_pkg::SIGN_W+rwu_pkg::STEP_W-1:0] rd_data,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  wire logic [rwu_pkg::SIGN_W+rwu_pkg::STEP_W-1:0] wr_data,
   output logic                           clr_busy
);

   localparam int unsigned ADDR_W = $clog2(ENTRIES);
   localparam int unsigned DATA_W = rwu_pkg::SIGN_W + rwu_pkg::STEP_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);

   logic [DATA_W-1:0] mem [ENTRIES];
   logic [DATA_W-1:0] rd_data_ff;
   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [DATA_W-1:0] mem_wdata;

   // clear pass owns the write port after reset
   always_comb begin
      if (clr_busy_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = {rwu_pkg::SIGN_ZERO, rwu_pkg::STEP_RST};
      end else begin
         mem_we    = wr_en;
         mem_waddr = wr_addr;
         mem_wdata = wr_data;
      end
   end

   // clear sequencer, one entry per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // storage, read returns old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_busy_ff;

endmodule

`default_nettype wire

// ----- rtl/rwu_step_calc.sv -----
`default_nettype none

module rwu_step_calc (
   input  wire logic [rwu_pkg::STEP_W-1:0] step_old,
   input  wire logic [rwu_pkg::SIGN_W-1:0] sign_old,
   input  wire logic [rwu_pkg::SIGN_W-1:0] grad_sign,
   input  wire rwu_pkg::cfg_type           cfg,
   output rwu_pkg::upd_type                upd
);

   logic                              prev_nz;
   logic                              grad_nz;
   logic                              agree;
   logic                              differ;
   logic [rwu_pkg::PROD_W-1:0]        div_prod;
   logic [rwu_pkg::STEP_W:0]          grown;
   logic [rwu_pkg::STEP_W-1:0]        grown_cap;
   logic [rwu_pkg::STEP_W-1:0]        halved;
   logic [rwu_pkg::STEP_W-1:0]        halved_floor;

   // sign comparison, a stored sign code of three counts as zero
   assign prev_nz = (sign_old == rwu_pkg::SIGN_POS) || (sign_old == rwu_pkg::SIGN_NEG);
   assign grad_nz = (grad_sign != rwu_pkg::SIGN_ZERO);
   assign agree   = prev_nz && grad_nz && (sign_old == grad_sign);
   assign differ  = prev_nz && grad_nz && (sign_old != grad_sign);

   // grow: s * 6 / 5 = s + floor(s / 5), capped at step_max
   assign div_prod  = step_old * rwu_pkg::DIV5_MUL;
   assign grown     = {1'b0, step_old} +
                      (rwu_pkg::STEP_W+1)'(div_prod >> rwu_pkg::DIV5_SHIFT);
   assign grown_cap = (grown > {1'b0, cfg.step_max}) ? cfg.step_max
                                                      : grown[rwu_pkg::STEP_W-1:0];

   // shrink: halve, floored at step_min
   assign halved       = step_old >> 1;
   assign halved_floor = (halved < cfg.step_min) ? cfg.step_min : halved;

   // case select
   always_comb begin
      if (agree) begin
         upd.step  = grown_cap;
         upd.sign  = grad_sign;
         upd.ucase = rwu_pkg::UCASE_GROW;
         upd.move  = 1'b1;
      end else if (differ) begin
         upd.step  = halved_floor;
         upd.sign  = rwu_pkg::SIGN_ZERO;
         upd.ucase = rwu_pkg::UCASE_SHRINK;
         upd.move  = 1'b0;
      end else begin
         upd.step  = step_old;
         upd.sign  = grad_sign;
         upd.ucase = rwu_pkg::UCASE_KEEP;
         upd.move  = grad_nz;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/rwu_weight_move.sv -----
`default_nettype none

module rwu_weight_move (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            adv,
   input  wire logic                            in_valid,
   input  wire rwu_pkg::mv_type                 mv,
   input  wire logic [rwu_pkg::CFG_W-1:0]       learn_rate,
   output logic                                 out_valid,
   output logic signed [rwu_pkg::WEIGHT_W-1:0]  weight_out,
   output logic [rwu_pkg::STEP_W-1:0]           step_out,
   output logic [rwu_pkg::CASE_W-1:0]           update_case
);

   localparam int unsigned SUM_W = rwu_pkg::WEIGHT_W + 2;
   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sh7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sh8000_0000);

   logic                          s2_valid_ff;
   rwu_pkg::mv_type               s2_mv_ff;
   logic                          s3_valid_ff;
   rwu_pkg::mv_type               s3_mv_ff;
   logic [rwu_pkg::PROD_W-1:0]    s3_prod_ff;
   logic [rwu_pkg::PROD_W-1:0]    prod_in;
   logic signed [SUM_W-1:0]       mag;
   logic signed [SUM_W-1:0]       wide_w;
   logic signed [SUM_W-1:0]       sum;
   logic signed [rwu_pkg::WEIGHT_W-1:0] sat_in;
   logic                          out_valid_ff;
   logic signed [rwu_pkg::WEIGHT_W-1:0] weight_out_ff;
   logic [rwu_pkg::STEP_W-1:0]    step_out_ff;
   logic [rwu_pkg::CASE_W-1:0]    ucase_ff;

   // stage 2: step times rate with rounding term
   assign prod_in = s2_mv_ff.step * learn_rate + rwu_pkg::ROUND_HALF;

   // stage 3: apply the move and saturate
   assign mag    = SUM_W'(s3_prod_ff[rwu_pkg::PROD_W-1:16]);
   assign wide_w = SUM_W'(s3_mv_ff.weight);
   always_comb begin
      if (!s3_mv_ff.move) begin
         sum = wide_w;
      end else if (s3_mv_ff.grad_neg) begin
         sum = wide_w + mag;
      end else begin
         sum = wide_w - mag;
      end
      if (sum > SAT_MAX) begin
         sat_in = rwu_pkg::WEIGHT_W'(SAT_MAX);
      end else if (sum < SAT_MIN) begin
         sat_in = rwu_pkg::WEIGHT_W'(SAT_MIN);
      end else begin
         sat_in = sum[rwu_pkg::WEIGHT_W-1:0];
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff  <= in_valid;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_mv_ff      <= mv;
         s3_mv_ff      <= s2_mv_ff;
         s3_prod_ff    <= prod_in;
         weight_out_ff <= sat_in;
         step_out_ff   <= s3_mv_ff.step;
         ucase_ff      <= s3_mv_ff.ucase;
      end
   end

   assign out_valid   = out_valid_ff;
   assign weight_out  = weight_out_ff;
   assign step_out    = step_out_ff;
   assign update_case = ucase_ff;

endmodule

`default_nettype wire

// ----- rtl/rwu_checker.sv -----
`default_nettype none

module rwu_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tvalid,
   input wire logic                      req_tready,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [rwu_pkg::RSP_W-1:0] rsp_tdata
);

   // input closed and no result valid right after reset, as the clear pass begins
   a_clear_blocks_input: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("input open or output valid right after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // a stalled output stalls the whole pipeline, input included
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while output stalled");

   // only defined update cases leave the block
   a_case_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[57:56] == rwu_pkg::UCASE_GROW) ||
                     (rsp_tdata[57:56] == rwu_pkg::UCASE_SHRINK) ||
                     (rsp_tdata[57:56] == rwu_pkg::UCASE_KEEP))
      else $error("undefined update case");

   // pad bits stay zero, checked when result and input are both valid
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && req_tvalid |-> rsp_tdata[63:58] == 6'd0)
      else $error("pad bits set in result word");

endmodule

bind rprop_weight_update_unit rwu_checker u_rwu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
